// ===== design/grid_cell_bbox_accumulator_macros.svh =====
// assertion macros for the grid cell box accumulator
// no dependencies
`ifndef GRID_CELL_BBOX_ACCUMULATOR_MACROS_SVH
`define GRID_CELL_BBOX_ACCUMULATOR_MACROS_SVH
`ifndef SYNTH
`define GCB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GCB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GCB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/gcba_pkg.sv =====
// types and constants for the grid cell box accumulator
// no dependencies
package gcba_pkg;
    localparam int MAX_SIDE_CELLS_DEF = 32;
    localparam int COORD_BITS_DEF = 32;
    localparam int CFG_W = 32;
    localparam int IDX_W = 10;
    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MIN_Y = 3'd1;
    localparam logic [2:0] REG_MAX_X = 3'd2;
    localparam logic [2:0] REG_MAX_Y = 3'd3;
    localparam logic [2:0] REG_SIDE  = 3'd4;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] box_lo_x;
        logic signed [31:0] box_lo_y;
        logic signed [31:0] box_lo_z;
        logic signed [31:0] box_hi_x;
        logic signed [31:0] box_hi_y;
        logic signed [31:0] box_hi_z;
    } t_in_word;

    typedef struct packed {
        logic [9:0]         cell_index;
        logic               was_in_use;
        logic signed [31:0] merged_lo_x;
        logic signed [31:0] merged_lo_y;
        logic signed [31:0] merged_lo_z;
        logic signed [31:0] merged_hi_x;
        logic signed [31:0] merged_hi_y;
        logic signed [31:0] merged_hi_z;
    } t_out_word;

    typedef struct packed {
        logic signed [31:0] lo_x;
        logic signed [31:0] lo_y;
        logic signed [31:0] lo_z;
        logic signed [31:0] hi_x;
        logic signed [31:0] hi_y;
        logic signed [31:0] hi_z;
    } t_box;

    function automatic logic [9:0] spread5(input logic [4:0] v);
        logic [9:0] r;
        r = '0;
        for (int k = 0; k < 5; k++) r[2*k] = v[k];
        return r;
    endfunction
endpackage

// ===== design/gcba_divider.sv =====
// restoring divider for the cell rescale: floor(num / den), one bit a cycle
// depends on gcba_pkg
module gcba_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [38:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_done,
    output logic [5:0]  o_quot
);
    import gcba_pkg::*;
    localparam int NB = 39;
    logic [NB-1:0] r_num, n_num;
    logic [33:0]   r_rem, n_rem;
    logic [32:0]   r_den;
    logic [5:0]    r_cnt, n_cnt;
    logic          r_run, n_run, r_done, n_done;
    logic [33:0]   w_sh;
    logic [34:0]   w_diff;

    always_comb begin
        n_num = r_num; n_rem = r_rem; n_cnt = r_cnt; n_run = r_run; n_done = 1'b0;
        w_sh = {r_rem[32:0], r_num[NB-1]};
        w_diff = {1'b0, w_sh} - {2'b0, r_den};
        if (r_run) begin
            n_num = {r_num[NB-2:0], 1'b0};
            if (!w_diff[34]) begin
                n_rem = w_diff[33:0];
                n_num[0] = 1'b1;
            end else begin
                n_rem = w_sh;
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_run = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_run <= i_go ? 1'b1 : n_run;
            r_done <= n_done;
            r_cnt <= i_go ? 6'(NB) : n_cnt;
        end
        if (i_go) begin
            r_num <= i_num; r_rem <= '0; r_den <= i_den;
        end else begin
            r_num <= n_num; r_rem <= n_rem;
        end
    end
    assign o_done = r_done;
    assign o_quot = r_num[5:0];
endmodule

// ===== design/gcba_store.sv =====
// cell box memory and used flag memory with registered read
// used flags are cleared one entry after another after reset; depends on gcba_pkg
module gcba_store #(
    parameter int DEPTH = 1024,
    parameter int AW = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [AW-1:0]          i_addr,
    input  logic                   i_we,
    input  gcba_pkg::t_box         i_wbox,
    output gcba_pkg::t_box         o_rbox,
    output logic                   o_rused,
    output logic                   o_clearing
);
    import gcba_pkg::*;
    t_box          r_mem [DEPTH];
    logic          r_used [DEPTH];
    logic [AW-1:0] r_clr_addr;
    logic          r_clr;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wbox;
        o_rbox <= r_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_clr) r_used[r_clr_addr] <= 1'b0;
        else if (i_we) r_used[i_addr] <= 1'b1;
        o_rused <= r_used[i_addr];
    end

    // clearing pass over all entries after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= 1'b1; r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) r_clr <= 1'b0;
        end
    end
    assign o_clearing = r_clr;
endmodule

// ===== design/grid_cell_bbox_accumulator.sv =====
// grid cell box accumulator top level: config, rescale sequencer, merge
// depends on gcba_pkg, gcba_divider, gcba_store, macros header
//
// usage: write grid bounds and cells_per_side through i_cfg_we/i_cfg_idx/
// i_cfg_data while idle. a word on i_in is taken when start is high and busy low.
// each axis whose point lies strictly inside the grid span goes through the
// shared bit-serial divider: a load, 39 steps and a hand-off of the quotient;
// an axis clamped to the grid edge or with an empty span skips the divider.
// the cell entry is then read (S_RD), merged and written back (S_WR),
// and the result word is shown for one cycle with o_valid, in S_OUT.
// busy stays high through S_OUT, so the next word is taken only after the
// result has been shown.
// the receiver cannot stall; results are never held.
// reset returns the config to its defaults; the used flags are then cleared
// one entry after another, so busy stays high after reset until all 1024 are clear.
`include "grid_cell_bbox_accumulator_macros.svh"
module grid_cell_bbox_accumulator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  gcba_pkg::t_in_word   i_in,
    output logic                 o_valid,
    output gcba_pkg::t_out_word  o_out,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data
);
    import gcba_pkg::*;
    localparam int MAX_SIDE_CELLS = MAX_SIDE_CELLS_DEF;
    localparam int DEPTH = MAX_SIDE_CELLS * MAX_SIDE_CELLS;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_X = 6'b000010, S_Y = 6'b000100,
        S_RD = 6'b001000, S_WR = 6'b010000, S_OUT = 6'b100000
    } t_state;

    t_state r_st;
    logic signed [31:0] r_min_x, r_min_y, r_max_x, r_max_y;
    logic [5:0] r_side;
    t_in_word r_in;
    logic [4:0] r_cx, r_cy;
    logic r_wait;
    logic [5:0] w_side;
    logic signed [31:0] w_lo, w_hi, w_c;
    logic w_under, w_over, w_go, w_done;
    logic [38:0] w_num;
    logic [32:0] w_den;
    logic [5:0] w_q;
    logic [9:0] w_code;
    logic [AW-1:0] w_addr;
    t_box w_rbox, w_nbox, w_ibox;
    logic w_rused, w_we, w_clr;

    always_comb begin
        w_side = (r_side == 6'd0) ? 6'd1 :
                 (r_side > 6'(MAX_SIDE_CELLS)) ? 6'(MAX_SIDE_CELLS) : r_side;
        w_lo = (r_st == S_Y) ? r_min_y : r_min_x;
        w_hi = (r_st == S_Y) ? r_max_y : r_max_x;
        w_c  = (r_st == S_Y) ? r_in.point_y : r_in.point_x;
        w_under = (w_c <= w_lo);
        w_over = !w_under && (w_c >= w_hi);
        w_num = 39'(33'($signed({w_c[31], w_c}) - $signed({w_lo[31], w_lo})) * w_side);
        w_den = 33'($signed({w_hi[31], w_hi}) - $signed({w_lo[31], w_lo}));
        w_go = ((r_st == S_X) || (r_st == S_Y)) && !r_wait && !w_under && !w_over;
        w_code = (spread5(r_cy) << 1) | spread5(r_cx);
        w_addr = AW'(w_code);
        w_ibox = {r_in.box_lo_x, r_in.box_lo_y, r_in.box_lo_z,
                  r_in.box_hi_x, r_in.box_hi_y, r_in.box_hi_z};
        w_nbox = w_ibox;
        if (w_rused) begin
            w_nbox.lo_x = (w_ibox.lo_x < w_rbox.lo_x) ? w_ibox.lo_x : w_rbox.lo_x;
            w_nbox.lo_y = (w_ibox.lo_y < w_rbox.lo_y) ? w_ibox.lo_y : w_rbox.lo_y;
            w_nbox.lo_z = (w_ibox.lo_z < w_rbox.lo_z) ? w_ibox.lo_z : w_rbox.lo_z;
            w_nbox.hi_x = (w_ibox.hi_x > w_rbox.hi_x) ? w_ibox.hi_x : w_rbox.hi_x;
            w_nbox.hi_y = (w_ibox.hi_y > w_rbox.hi_y) ? w_ibox.hi_y : w_rbox.hi_y;
            w_nbox.hi_z = (w_ibox.hi_z > w_rbox.hi_z) ? w_ibox.hi_z : w_rbox.hi_z;
        end
        w_we = (r_st == S_WR);
    end

    gcba_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(w_go), .i_num(w_num),
        .i_den(w_den), .o_done(w_done), .o_quot(w_q)
    );

    gcba_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_addr(w_addr), .i_we(w_we),
        .i_wbox(w_nbox), .o_rbox(w_rbox), .o_rused(w_rused), .o_clearing(w_clr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_wait <= 1'b0; o_valid <= 1'b0;
            r_min_x <= '0; r_min_y <= '0; r_max_x <= 32'sd256; r_max_y <= 32'sd256;
            r_side <= 6'd1;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MIN_X: r_min_x <= i_cfg_data;
                    REG_MIN_Y: r_min_y <= i_cfg_data;
                    REG_MAX_X: r_max_x <= i_cfg_data;
                    REG_MAX_Y: r_max_y <= i_cfg_data;
                    REG_SIDE:  r_side <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            unique case (r_st)
                S_IDLE: if (start && !w_clr) begin
                    r_in <= i_in; r_st <= S_X;
                end
                S_X, S_Y: begin
                    if (r_wait) begin
                        if (w_done) begin
                            r_wait <= 1'b0;
                            if (r_st == S_X) r_cx <= w_q[4:0]; else r_cy <= w_q[4:0];
                            r_st <= (r_st == S_X) ? S_Y : S_RD;
                        end
                    end else if (w_go) begin
                        r_wait <= 1'b1;
                    end else begin
                        if (r_st == S_X) r_cx <= w_under ? 5'd0 : 5'(w_side - 6'd1);
                        else r_cy <= w_under ? 5'd0 : 5'(w_side - 6'd1);
                        r_st <= (r_st == S_X) ? S_Y : S_RD;
                    end
                end
                S_RD: r_st <= S_WR;
                S_WR: begin
                    o_out <= {w_code, w_rused, w_nbox};
                    o_valid <= 1'b1;
                    r_st <= S_OUT;
                end
                S_OUT: r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
    assign busy = (r_st != S_IDLE) || w_clr;

    `GCB_ASSERT_NEXT(a_out_once, i_clk, i_rst_n, o_valid, !o_valid)
    `GCB_ASSERT_NEXT(a_wr_then_out, i_clk, i_rst_n, r_st == S_WR, o_valid)
    `GCB_ASSERT_IMPL(a_go_idle_div, i_clk, i_rst_n, w_go, !r_wait)
endmodule

// ===== tb/tb_grid_cell_bbox_accumulator.sv =====
// testbench for grid_cell_bbox_accumulator: random and directed words checked
// against an in-bench predictor of grid rescale, morton index and box merge
// depends on gcba_pkg and the grid_cell_bbox_accumulator rtl
`timescale 1ns / 1ps
module tb_grid_cell_bbox_accumulator;
    import gcba_pkg::*;

    localparam int SIDE_MAX = 32;
    localparam longint CYCLE_LIMIT = 2000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_word    i_in;
    logic        o_valid;
    t_out_word   o_out;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    grid_cell_bbox_accumulator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_in(i_in), .o_valid(o_valid), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic signed [31:0] gmin_x, gmin_y, gmax_x, gmax_y;
    logic [5:0]         gside;
    bit                 used_flag [1024];
    t_box               cell_box [1024];

    t_in_word  pending_words [$];
    t_out_word expected_words [$];
    int        errors;
    longint    cycles;
    bit        drv_sent;
    int        burst_left, gap_left;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic logic [4:0] grid_cell(input logic signed [31:0] lo,
            input logic signed [31:0] hi, input logic signed [31:0] c,
            input int side);
        longint offs, span;
        if (c <= lo) return 5'd0;
        if (c >= hi) return 5'(side - 1);
        offs = longint'(c) - longint'(lo);
        span = longint'(hi) - longint'(lo);
        return 5'((offs * side) / span);
    endfunction

    function automatic logic [9:0] morton_code(input logic [4:0] cy,
            input logic [4:0] cx);
        logic [9:0] r;
        r = '0;
        for (int k = 0; k < 5; k++) begin
            r[2*k]   = cx[k];
            r[2*k+1] = cy[k];
        end
        return r;
    endfunction

    function automatic t_out_word bin_and_merge(input t_in_word w);
        t_out_word r;
        int side;
        logic [9:0] code;
        t_box b;
        side = gside;
        if (side == 0) side = 1;
        if (side > SIDE_MAX) side = SIDE_MAX;
        code = morton_code(grid_cell(gmin_y, gmax_y, w.point_y, side),
                           grid_cell(gmin_x, gmax_x, w.point_x, side));
        r.cell_index = code;
        r.was_in_use = used_flag[code];
        if (used_flag[code]) begin
            b = cell_box[code];
            if (w.box_lo_x < b.lo_x) b.lo_x = w.box_lo_x;
            if (w.box_lo_y < b.lo_y) b.lo_y = w.box_lo_y;
            if (w.box_lo_z < b.lo_z) b.lo_z = w.box_lo_z;
            if (w.box_hi_x > b.hi_x) b.hi_x = w.box_hi_x;
            if (w.box_hi_y > b.hi_y) b.hi_y = w.box_hi_y;
            if (w.box_hi_z > b.hi_z) b.hi_z = w.box_hi_z;
        end else begin
            b = {w.box_lo_x, w.box_lo_y, w.box_lo_z, w.box_hi_x, w.box_hi_y, w.box_hi_z};
        end
        used_flag[code] = 1'b1;
        cell_box[code] = b;
        r.merged_lo_x = b.lo_x; r.merged_lo_y = b.lo_y; r.merged_lo_z = b.lo_z;
        r.merged_hi_x = b.hi_x; r.merged_hi_y = b.hi_y; r.merged_hi_z = b.hi_z;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_words.push_back(bin_and_merge(i_in));
                drv_sent = 1'b1;
            end else begin
                drv_sent = 1'b0;
            end
            if (start && !busy) begin
                if (burst_left > 0) burst_left = burst_left - 1;
            end
            if (!start || drv_sent) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    start <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    i_in <= pending_words.pop_front();
                    start <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 8);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_valid) begin
            if (expected_words.size() == 0) begin
                $display("%0t unexpected word: exp none act %h", $time, o_out);
                errors++;
            end else begin
                e = expected_words.pop_front();
                if (o_out.cell_index !== e.cell_index)
                    $display("%0t cell_index exp %h act %h", $time, e.cell_index, o_out.cell_index);
                if (o_out.was_in_use !== e.was_in_use)
                    $display("%0t was_in_use exp %h act %h", $time, e.was_in_use, o_out.was_in_use);
                if (o_out.merged_lo_x !== e.merged_lo_x)
                    $display("%0t merged_lo_x exp %h act %h", $time, e.merged_lo_x, o_out.merged_lo_x);
                if (o_out.merged_lo_y !== e.merged_lo_y)
                    $display("%0t merged_lo_y exp %h act %h", $time, e.merged_lo_y, o_out.merged_lo_y);
                if (o_out.merged_lo_z !== e.merged_lo_z)
                    $display("%0t merged_lo_z exp %h act %h", $time, e.merged_lo_z, o_out.merged_lo_z);
                if (o_out.merged_hi_x !== e.merged_hi_x)
                    $display("%0t merged_hi_x exp %h act %h", $time, e.merged_hi_x, o_out.merged_hi_x);
                if (o_out.merged_hi_y !== e.merged_hi_y)
                    $display("%0t merged_hi_y exp %h act %h", $time, e.merged_hi_y, o_out.merged_hi_y);
                if (o_out.merged_hi_z !== e.merged_hi_z)
                    $display("%0t merged_hi_z exp %h act %h", $time, e.merged_hi_z, o_out.merged_hi_z);
                if (o_out !== e) errors++;
            end
        end
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 1024) - 512;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in_word rand_word(input logic signed [31:0] lx,
            input logic signed [31:0] hx, input logic signed [31:0] ly,
            input logic signed [31:0] hy);
        t_in_word w;
        longint spx, spy;
        spx = longint'(hx) - longint'(lx);
        spy = longint'(hy) - longint'(ly);
        if ($urandom_range(0, 4) != 0 && spx > 0 && spy > 0) begin
            w.point_x = 32'(longint'(lx) + (longint'({$urandom(), $urandom()}) & 64'h7fff_ffff_ffff)
                        % (spx + 1));
            w.point_y = 32'(longint'(ly) + (longint'({$urandom(), $urandom()}) & 64'h7fff_ffff_ffff)
                        % (spy + 1));
        end else begin
            w.point_x = pick_coord();
            w.point_y = pick_coord();
        end
        w.box_lo_x = pick_coord(); w.box_lo_y = pick_coord(); w.box_lo_z = pick_coord();
        w.box_hi_x = pick_coord(); w.box_hi_y = pick_coord(); w.box_hi_z = pick_coord();
        return w;
    endfunction

    task automatic wait_idle();
        while (pending_words.size() > 0 || start || busy || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_MIN_X: gmin_x = val;
            REG_MIN_Y: gmin_y = val;
            REG_MAX_X: gmax_x = val;
            REG_MAX_Y: gmax_y = val;
            REG_SIDE:  gside = val[5:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_grid(input logic [31:0] mnx, input logic [31:0] mny,
            input logic [31:0] mxx, input logic [31:0] mxy, input logic [31:0] sd);
        write_reg(REG_MIN_X, mnx);
        write_reg(REG_MIN_Y, mny);
        write_reg(REG_MAX_X, mxx);
        write_reg(REG_MAX_Y, mxy);
        write_reg(REG_SIDE, sd);
    endtask

    task automatic run_phase(input int n);
        for (int k = 0; k < n; k++)
            pending_words.push_back(rand_word(gmin_x, gmax_x, gmin_y, gmax_y));
        wait_idle();
    endtask

    initial begin
        t_in_word w;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_in = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        errors = 0;
        cycles = 0;
        burst_left = 0;
        gap_left = 0;
        gmin_x = 0; gmin_y = 0; gmax_x = 256; gmax_y = 256; gside = 1;
        for (int k = 0; k < 1024; k++) begin
            used_flag[k] = 1'b0;
            cell_box[k] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: defaults, extremes, inverted box, merge into same cell
        w = '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0, 32'h8000_0000,
              32'h7fff_ffff, 0};
        pending_words.push_back(w);
        w = '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 5, 32'h7fff_ffff,
              32'h8000_0000, 3};
        pending_words.push_back(w);
        wait_idle();
        set_grid(0, 0, 32'd8192, 32'd8192, 32);
        w = '{0, 0, 1, 2, 3, 4, 5, 6};
        pending_words.push_back(w);
        w = '{32'd8191, 32'd8191, 7, 7, 7, 7, 7, 7};
        pending_words.push_back(w);
        w = '{32'd8192, 32'd8192, 1, 1, 1, 1, 1, 1};
        pending_words.push_back(w);
        w = '{32'd256, 32'd4096, -1, -1, -1, 9, 9, 9};
        pending_words.push_back(w);
        w = '{32'd257, 32'd4100, 32'h8000_0000, 0, 4, 32'h7fff_ffff, 1, 9};
        pending_words.push_back(w);
        wait_idle();
        // zero side, oversize side, odd side, inverted span
        set_grid(32'd100, 32'd100, 32'd100, 32'd50, 0);
        pending_words.push_back('{32'd100, 32'd101, 1, 1, 1, 2, 2, 2});
        wait_idle();
        write_reg(REG_SIDE, 63);
        pending_words.push_back('{32'd101, 32'd100, 1, 1, 1, 2, 2, 2});
        pending_words.push_back('{32'd99, 32'd200, 1, 1, 1, 2, 2, 2});
        wait_idle();
        set_grid(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 7);
        pending_words.push_back('{32'h0, 32'hffff_ffff, 3, 3, 3, 3, 3, 3});
        pending_words.push_back('{32'h7fff_fffe, 32'h8000_0001, 3, 3, 3, 3, 3, 3});
        wait_idle();
        write_reg(3'd6, 32'hdead_beef);
        write_reg(3'd7, 32'h1234_5678);

        // random phases
        run_phase(100);
        set_grid(-32'sd4096, -32'sd2048, 32'd4096, 32'd2048, 32);
        run_phase(150);
        set_grid($urandom(), $urandom(), $urandom(), $urandom(), $urandom_range(0, 63));
        run_phase(60);
        set_grid(0, 0, 32'd64, 32'd64, 4);
        run_phase(120);
        set_grid(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 16);
        run_phase(100);
        set_grid(-32'sd1000, 32'd10, 32'd3000, 32'd77777, 5);
        run_phase(70);

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
